// ===== src/hk_pkg.sv =====
// Shared types, character codes and name matching for the hotkey report block.
`default_nettype none
package hk_pkg;

	localparam int unsigned NAME_CHARS = 16;  // longest key or modifier name
	localparam int unsigned OUT_SLOTS  = 6;   // key slots shown on the report

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_HYPH  = 8'h2D;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [7:0] USE_A      = 8'h04;
	localparam logic [7:0] USE_1      = 8'h1E;
	localparam logic [7:0] USE_0      = 8'h27;
	localparam logic [7:0] USE_ENTER  = 8'h28;
	localparam logic [7:0] USE_ESC    = 8'h29;
	localparam logic [7:0] USE_BKSP   = 8'h2A;
	localparam logic [7:0] USE_TAB    = 8'h2B;
	localparam logic [7:0] USE_SPACE  = 8'h2C;
	localparam logic [7:0] USE_F1     = 8'h3A;
	localparam logic [7:0] USE_RIGHT  = 8'h4F;
	localparam logic [7:0] USE_LEFT   = 8'h50;
	localparam logic [7:0] USE_DOWN   = 8'h51;
	localparam logic [7:0] USE_UP     = 8'h52;

	localparam logic [7:0] MOD_LCTRL  = 8'h01;
	localparam logic [7:0] MOD_LSHIFT = 8'h02;
	localparam logic [7:0] MOD_LALT   = 8'h04;
	localparam logic [7:0] MOD_LGUI   = 8'h08;
	localparam logic [7:0] MOD_RCTRL  = 8'h10;
	localparam logic [7:0] MOD_RSHIFT = 8'h20;
	localparam logic [7:0] MOD_RALT   = 8'h40;
	localparam logic [7:0] MOD_RGUI   = 8'h80;

	// Current token as seen after the beat's character is appended.
	typedef struct packed {
		logic [NAME_CHARS-1:0][7:0] chars;    // first NAME_CHARS bytes
		logic [4:0]                 len;      // exact while not long_tok
		logic                       long_tok; // longer than any name
		logic                       empty;
		logic                       overflow;
		logic                       f_lead;   // first byte is 'f'
		logic                       f_digits; // every later byte is a digit
		logic [3:0]                 f_num;    // decimal value, saturated at 13
	} tok_view_t;

	typedef struct packed {
		logic       is_fn;
		logic [7:0] mods;
		logic [7:0] usage;
	} match_t;

	typedef struct packed {
		logic                      rvalid;
		logic [7:0]                mods;
		logic [7:0]                primary;
		logic [OUT_SLOTS-1:0][7:0] slots;
	} report_t;

	// nm holds a string literal, right justified, of n characters.
	function automatic logic name_is(input tok_view_t t,
			input logic [8*NAME_CHARS-1:0] nm, input int unsigned n);
		logic ok;
		ok = !t.long_tok && (t.len == 5'(n));
		for (int unsigned i = 0; i < NAME_CHARS; i++) begin
			if (i < n) begin
				ok = ok && (t.chars[i] == nm[8*(n-1-i) +: 8]);
			end
		end
		return ok;
	endfunction

endpackage
`default_nettype wire

// ===== src/hk_token.sv =====
// Token buffer: holds the current token and running F-key digit state.
`default_nettype none
module hk_token #(
	parameter int unsigned MAX_TOKEN_LEN = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,     // beat in stage 1 is consumed
	input  wire logic              app,     // beat carries a token byte
	input  wire logic              finish,  // token ends on this beat
	input  wire logic [7:0]        char_in,
	output hk_pkg::tok_view_t      view
);
	import hk_pkg::*;

	localparam int unsigned LW = $clog2(MAX_TOKEN_LEN + 1);

	logic [NAME_CHARS-1:0][7:0] chars_q;
	logic [LW-1:0]              len_q;
	logic                       ovf_q;
	logic                       f_lead_q;
	logic                       f_dig_q;
	logic [3:0]                 f_num_q;

	logic [7:0]    lc;
	logic          fits;
	logic          is_dig;
	logic [7:0]    acc;
	logic [LW-1:0] len_v;
	logic          f_lead_v;
	logic          f_dig_v;
	logic [3:0]    f_num_v;

	always_comb begin
		lc = char_in;
		if (char_in >= CH_UP_A && char_in <= CH_UP_Z) begin
			lc = char_in | 8'h20;
		end
		fits   = app && (len_q != LW'(MAX_TOKEN_LEN));
		is_dig = (lc >= CH_0) && (lc <= CH_9);
		acc    = {4'b0, f_num_q} * 8'd10 + (lc - CH_0);

		len_v    = len_q + LW'(fits);
		f_lead_v = f_lead_q;
		f_dig_v  = f_dig_q;
		f_num_v  = f_num_q;
		if (fits) begin
			if (len_q == '0) begin
				f_lead_v = (lc == CH_LO_F);
				f_dig_v  = 1'b1;
				f_num_v  = '0;
			end else begin
				f_dig_v = f_dig_q && is_dig;
				if (is_dig) begin
					f_num_v = (acc > 8'd13) ? 4'd13 : acc[3:0];
				end
			end
		end

		for (int unsigned i = 0; i < NAME_CHARS; i++) begin
			view.chars[i] = (fits && len_q == LW'(i)) ? lc : chars_q[i];
		end
		view.len      = len_v[4:0];
		view.long_tok = (len_v > LW'(NAME_CHARS));
		view.empty    = (len_v == '0);
		view.overflow = ovf_q || (app && !fits);
		view.f_lead   = f_lead_v;
		view.f_digits = f_dig_v;
		view.f_num    = f_num_v;
	end

	always_ff @(posedge clk) begin
		for (int unsigned i = 0; i < NAME_CHARS; i++) begin
			if (adv && fits && len_q == LW'(i)) begin
				chars_q[i] <= lc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			ovf_q    <= 1'b0;
			f_lead_q <= 1'b0;
			f_dig_q  <= 1'b0;
			f_num_q  <= '0;
		end else if (adv) begin
			if (finish) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				len_q <= len_v;
				ovf_q <= view.overflow;
			end
			f_lead_q <= f_lead_v;
			f_dig_q  <= f_dig_v;
			f_num_q  <= f_num_v;
		end
	end

endmodule
`default_nettype wire

// ===== src/hk_match.sv =====
// Token decoder: fn names, modifier names and key names to HID codes.
`default_nettype none
module hk_match (
	input  wire hk_pkg::tok_view_t view,
	output hk_pkg::match_t         mt
);
	import hk_pkg::*;

	logic [7:0] c0;

	always_comb begin
		c0 = view.chars[0];
		mt.is_fn = name_is(view, "fn", 2) || name_is(view, "function", 8);

		if (name_is(view, "ctrl", 4) || name_is(view, "control", 7) ||
				name_is(view, "commandorcontrol", 16) ||
				name_is(view, "leftctrl", 8) || name_is(view, "leftcontrol", 11)) begin
			mt.mods = MOD_LCTRL;
		end else if (name_is(view, "shift", 5) || name_is(view, "leftshift", 9)) begin
			mt.mods = MOD_LSHIFT;
		end else if (name_is(view, "alt", 3) || name_is(view, "option", 6) ||
				name_is(view, "leftalt", 7) || name_is(view, "leftoption", 10)) begin
			mt.mods = MOD_LALT;
		end else if (name_is(view, "meta", 4) || name_is(view, "gui", 3) ||
				name_is(view, "cmd", 3) || name_is(view, "command", 7) ||
				name_is(view, "leftmeta", 8) || name_is(view, "leftgui", 7) ||
				name_is(view, "leftcmd", 7) || name_is(view, "leftcommand", 11)) begin
			mt.mods = MOD_LGUI;
		end else if (name_is(view, "rightctrl", 9) || name_is(view, "rightcontrol", 12)) begin
			mt.mods = MOD_RCTRL;
		end else if (name_is(view, "rightshift", 10)) begin
			mt.mods = MOD_RSHIFT;
		end else if (name_is(view, "altgr", 5) || name_is(view, "rightalt", 8) ||
				name_is(view, "rightoption", 11)) begin
			mt.mods = MOD_RALT;
		end else if (name_is(view, "rightmeta", 9) || name_is(view, "rightgui", 8) ||
				name_is(view, "rightcmd", 8) || name_is(view, "rightcommand", 12)) begin
			mt.mods = MOD_RGUI;
		end else begin
			mt.mods = '0;
		end

		mt.usage = '0;
		if (!view.long_tok && view.len == 5'd1 && c0 >= CH_LO_A && c0 <= CH_LO_Z) begin
			mt.usage = USE_A + (c0 - CH_LO_A);
		end else if (!view.long_tok && view.len == 5'd1 && c0 >= CH_1 && c0 <= CH_9) begin
			mt.usage = USE_1 + (c0 - CH_1);
		end else if (!view.long_tok && view.len == 5'd1 && c0 == CH_0) begin
			mt.usage = USE_0;
		end else if (name_is(view, "enter", 5) || name_is(view, "return", 6)) begin
			mt.usage = USE_ENTER;
		end else if (name_is(view, "escape", 6) || name_is(view, "esc", 3)) begin
			mt.usage = USE_ESC;
		end else if (name_is(view, "backspace", 9)) begin
			mt.usage = USE_BKSP;
		end else if (name_is(view, "tab", 3)) begin
			mt.usage = USE_TAB;
		end else if (name_is(view, "space", 5) || name_is(view, "spacebar", 8)) begin
			mt.usage = USE_SPACE;
		end else if (name_is(view, "arrowright", 10) || name_is(view, "right", 5)) begin
			mt.usage = USE_RIGHT;
		end else if (name_is(view, "arrowleft", 9) || name_is(view, "left", 4)) begin
			mt.usage = USE_LEFT;
		end else if (name_is(view, "arrowdown", 9) || name_is(view, "down", 4)) begin
			mt.usage = USE_DOWN;
		end else if (name_is(view, "arrowup", 7) || name_is(view, "up", 2)) begin
			mt.usage = USE_UP;
		end else if ((view.long_tok || view.len >= 5'd2) && view.f_lead && view.f_digits &&
				view.f_num >= 4'd1 && view.f_num <= 4'd12) begin
			mt.usage = USE_F1 + {4'b0, view.f_num - 4'd1};
		end
	end

endmodule
`default_nettype wire

// ===== src/hk_report.sv =====
// Report builder: modifier mask, key slots, reject flag and result register.
`default_nettype none
module hk_report #(
	parameter int unsigned KEY_SLOTS = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              last,
	input  wire logic              finish,
	input  wire hk_pkg::tok_view_t view,
	input  wire hk_pkg::match_t    mt,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output hk_pkg::report_t        rpt
);
	import hk_pkg::*;

	localparam int unsigned NSHOW = (KEY_SLOTS < OUT_SLOTS) ? KEY_SLOTS : OUT_SLOTS;

	logic [7:0]                mod_q;
	logic [KEY_SLOTS-1:0][7:0] slots_q;
	logic [7:0]                first_q;
	logic                      saw_q;
	logic                      fail_q;
	logic                      out_valid_q;
	report_t                   rpt_q;

	logic [7:0]                mod_n;
	logic [KEY_SLOTS-1:0][7:0] slots_n;
	logic [7:0]                first_n;
	logic                      saw_n;
	logic                      fail_n;
	logic                      dup;
	logic                      placed;
	logic                      ok;
	report_t                   rpt_n;

	always_comb begin
		mod_n   = mod_q;
		slots_n = slots_q;
		first_n = first_q;
		saw_n   = saw_q;
		fail_n  = fail_q;
		dup     = 1'b0;
		placed  = 1'b0;
		for (int unsigned i = 0; i < KEY_SLOTS; i++) begin
			dup = dup || (slots_q[i] == mt.usage);
		end
		if (finish && (!view.empty || view.overflow)) begin
			saw_n = 1'b1;
			if (!fail_q) begin
				if (view.overflow || mt.is_fn) begin
					fail_n = 1'b1;
				end else if (mt.mods != '0) begin
					mod_n = mod_q | mt.mods;
				end else if (mt.usage == '0 || dup) begin
					fail_n = 1'b1;
				end else begin
					// slots fill in order and are never freed mid-string
					for (int unsigned i = 0; i < KEY_SLOTS; i++) begin
						if (!placed && slots_q[i] == '0) begin
							slots_n[i] = mt.usage;
							placed     = 1'b1;
						end
					end
					if (!placed) begin
						fail_n = 1'b1;
					end else if (first_q == '0) begin
						first_n = mt.usage;
					end
				end
			end
		end

		ok    = !fail_n && saw_n && (mod_n != '0 || first_n != '0);
		rpt_n = '0;
		if (ok) begin
			rpt_n.rvalid  = 1'b1;
			rpt_n.mods    = mod_n;
			rpt_n.primary = first_n;
			for (int unsigned i = 0; i < NSHOW; i++) begin
				rpt_n.slots[i] = slots_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q       <= '0;
			slots_q     <= '0;
			first_q     <= '0;
			saw_q       <= 1'b0;
			fail_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				if (last) begin
					mod_q   <= '0;
					slots_q <= '0;
					first_q <= '0;
					saw_q   <= 1'b0;
					fail_q  <= 1'b0;
				end else begin
					mod_q   <= mod_n;
					slots_q <= slots_n;
					first_q <= first_n;
					saw_q   <= saw_n;
					fail_q  <= fail_n;
				end
			end
			if (adv && last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last) begin
			rpt_q <= rpt_n;
		end
	end

	assign out_valid = out_valid_q;
	assign rpt       = rpt_q;

	a_fail_saw: assert property (@(posedge clk) disable iff (!arst_n)
		fail_q |-> saw_q)
		else $error("reject flag set with no token seen");

	a_first_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		first_q == slots_q[0])
		else $error("primary key differs from slot 0");

	a_zero_report: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rpt_q.rvalid) |->
			(rpt_q.mods == '0 && rpt_q.primary == '0 && rpt_q.slots == '0))
		else $error("invalid report carries nonzero fields");

endmodule
`default_nettype wire

// ===== src/hotkey_text_to_hid_report.sv =====
// Top level: input register, token buffer, decoder and report builder.
`default_nettype none
// Parses a hotkey string such as "Ctrl+Shift+A", one byte per beat, and gives
// one HID boot keyboard report on the beat marked is_last (no_char marks a
// beat with no byte). Throughput is one character per clock: each beat is
// captured in an input register, from which a single pass of token decode,
// modifier merge and slot placement updates the parse state and, on the last
// beat, loads the result register that drives result_valid. The input side
// stalls only while a last beat waits for a result register that still
// holds an untaken report.
module hotkey_text_to_hid_report #(
	parameter int unsigned MAX_TOKEN_LEN = 16,
	parameter int unsigned KEY_SLOTS     = 6
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire logic [7:0] text_char,
	input  wire logic       is_last,
	input  wire logic       no_char,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic            report_valid,
	output logic [7:0]      modifier_bits,
	output logic [7:0]      primary_keycode,
	output logic [7:0]      key_slot_0,
	output logic [7:0]      key_slot_1,
	output logic [7:0]      key_slot_2,
	output logic [7:0]      key_slot_3,
	output logic [7:0]      key_slot_4,
	output logic [7:0]      key_slot_5
);
	import hk_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       nochar_s1;

	logic      adv;
	logic      accept;
	logic      plus;
	logic      app;
	logic      finish;
	tok_view_t view;
	match_t    mt;
	report_t   rpt;

	assign adv        = valid_s1 && (!last_s1 || !result_valid || !result_stall);
	assign item_stall = valid_s1 && !adv;
	assign accept     = item_valid && !item_stall;

	assign plus   = !nochar_s1 && (char_s1 == CH_PLUS);
	assign app    = !nochar_s1 && !plus && (char_s1 != CH_SPACE) &&
		(char_s1 != CH_UNDER) && (char_s1 != CH_HYPH);
	assign finish = plus || last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1   <= text_char;
			last_s1   <= is_last;
			nochar_s1 <= no_char;
		end
	end

	hk_token #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_token (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.app    (app),
		.finish (finish),
		.char_in(char_s1),
		.view   (view)
	);

	hk_match u_match (
		.view(view),
		.mt  (mt)
	);

	hk_report #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_report (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.last     (last_s1),
		.finish   (adv && finish),
		.view     (view),
		.mt       (mt),
		.out_stall(result_stall),
		.out_valid(result_valid),
		.rpt      (rpt)
	);

	assign report_valid    = rpt.rvalid;
	assign modifier_bits   = rpt.mods;
	assign primary_keycode = rpt.primary;
	assign key_slot_0      = rpt.slots[0];
	assign key_slot_1      = rpt.slots[1];
	assign key_slot_2      = rpt.slots[2];
	assign key_slot_3      = rpt.slots[3];
	assign key_slot_4      = rpt.slots[4];
	assign key_slot_5      = rpt.slots[5];

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && last_s1 && result_valid && result_stall))
		else $error("input stalled without a waiting last beat");

endmodule
`default_nettype wire
